/* hdl/sdss_pkg.sv */
package sdss_pkg;

    // default number of display digits
    localparam int NUM_DIGITS_DEF = 4;

    // width of the digit enable field (one bit per physical digit)
    localparam int EN_W = 4;

    // item kinds
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // ASCII digit range
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    // all segments off
    localparam logic [7:0] SEG_BLANK = 8'hFF;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]      segments;
        logic [EN_W-1:0] digit_enable;
    } t_out_item;

    // active-low common-anode segment code, point kept off
    function automatic logic [7:0] seg_code(input logic [3:0] value);
        logic [7:0] code;
        case (value)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

/* hdl/sdss_seg_decode.sv */
module sdss_seg_decode #(
    parameter int NUM_DIGITS = sdss_pkg::NUM_DIGITS_DEF,
    localparam int POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1
) (
    input  logic [3:0]         i_value,
    input  logic [POS_W-1:0]   i_pos,
    output sdss_pkg::t_out_item o_item
);

    // segment pattern for the stored digit and one-cold enable;
    // positions past the physical digits drive nothing
    always_comb begin
        o_item.segments     = sdss_pkg::seg_code(i_value);
        o_item.digit_enable = '1;
        for (int i = 0; i < sdss_pkg::EN_W; i++) begin
            if (i < NUM_DIGITS) begin
                if (i_pos == POS_W'(i)) begin
                    o_item.digit_enable[i] = 1'b0;
                end
            end
        end
    end

endmodule

/* hdl/serial_digit_entry_seven_seg_scan_unit.sv */
// Serial digit entry with multiplexed seven-segment scan.
//
// Input channel (i_in_valid / o_in_ready / i_in_item) carries either a
// received serial byte (action = byte) or a display refresh tick.
// ASCII digits fill the digit store in order; any other byte restarts
// entry at the first position. Once every digit has been entered the
// display is armed for good, and from then on each tick produces one
// result on the output channel (o_out_valid / i_out_ready / o_out_item):
// the segment code of the digit at the scan position and a one-cold
// digit enable. Bytes, and ticks before arming, produce no result.
//
// Throughput is one item per cycle unless a result-producing tick is
// stalled. An item waits in the input register, where state is updated
// and the result decoded; the result then goes to the result register,
// which drives o_out_valid. If the receiver stalls, the result register
// holds its item; bytes and unarmed ticks keep draining, and o_in_ready
// drops only while a result-producing tick waits in the input register.
// Reset clears entry position, scan position, the armed flag and all
// valid bits; the digit store has no reset and is filled by entry.
module serial_digit_entry_seven_seg_scan_unit #(
    parameter int NUM_DIGITS = sdss_pkg::NUM_DIGITS_DEF,
    localparam int POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sdss_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sdss_pkg::t_out_item o_out_item
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_DIGITS - 1);

    logic               r_s1_valid;
    sdss_pkg::t_in_item r_s1;
    logic [3:0]         r_store [NUM_DIGITS];
    logic [POS_W-1:0]   r_entry_pos;
    logic [POS_W-1:0]   r_scan_pos;
    logic               r_ready;
    logic               r_out_valid;
    sdss_pkg::t_out_item r_out;

    logic [POS_W-1:0]   n_entry_pos;
    logic [POS_W-1:0]   n_scan_pos;
    logic               n_ready;
    logic               w_is_digit;
    logic [7:0]         w_diff;
    logic               w_has_result;
    logic               w_out_free;
    logic               w_s1_fire;
    sdss_pkg::t_out_item w_result;

    // handshake: stage 1 drains unless it holds a result the output cannot take
    assign w_has_result = r_s1_valid && (r_s1.action == sdss_pkg::ACT_TICK) && r_ready;
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_s1_fire    = r_s1_valid && (!w_has_result || w_out_free);
    assign o_in_ready   = !r_s1_valid || w_s1_fire;

    // digit classification
    assign w_is_digit = (r_s1.rx_byte >= sdss_pkg::ASCII_ZERO)
                     && (r_s1.rx_byte <= sdss_pkg::ASCII_NINE);
    assign w_diff     = r_s1.rx_byte - sdss_pkg::ASCII_ZERO;

    // next state for entry and scan
    always_comb begin
        n_entry_pos = r_entry_pos;
        n_scan_pos  = r_scan_pos;
        n_ready     = r_ready;
        if (r_s1.action == sdss_pkg::ACT_BYTE) begin
            if (w_is_digit) begin
                if (r_entry_pos == LAST_POS) begin
                    n_entry_pos = '0;
                    n_ready     = 1'b1;
                end else begin
                    n_entry_pos = r_entry_pos + 1'b1;
                end
            end else begin
                n_entry_pos = '0;
            end
        end else if (r_ready) begin
            n_scan_pos = (r_scan_pos == LAST_POS) ? '0 : r_scan_pos + 1'b1;
        end
    end

    // segment and enable decode of the digit under scan
    sdss_seg_decode #(
        .NUM_DIGITS(NUM_DIGITS)
    ) u_decode (
        .i_value (r_store[r_scan_pos]),
        .i_pos   (r_scan_pos),
        .o_item  (w_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_s1 <= i_in_item;
        end
    end

    // control state, updated as an item leaves stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_pos <= '0;
            r_scan_pos  <= '0;
            r_ready     <= 1'b0;
        end else if (w_s1_fire) begin
            r_entry_pos <= n_entry_pos;
            r_scan_pos  <= n_scan_pos;
            r_ready     <= n_ready;
        end
    end

    // digit store, no reset
    always_ff @(posedge i_clk) begin
        if (w_s1_fire && (r_s1.action == sdss_pkg::ACT_BYTE) && w_is_digit) begin
            r_store[r_entry_pos] <= w_diff[3:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_fire && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_s1_fire && w_has_result) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // a result only exists once the display is armed
    a_result_after_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_ready)
        else $error("result present before digits ready");

    // armed flag never clears outside reset
    a_ready_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_ready))
        else $error("digits ready flag cleared");

    // at most one digit driven
    a_enable_one_cold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0(~r_out.digit_enable))
        else $error("more than one digit enabled");

    // positions stay inside the digit range
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_entry_pos <= LAST_POS) && (r_scan_pos <= LAST_POS))
        else $error("entry or scan position out of range");

    // a stalled result blocks its successor in stage 1
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && w_has_result) |=> (r_s1_valid && $stable(r_s1)))
        else $error("pending tick lost during output stall");

endmodule

/* bench/tb_serial_digit_entry_seven_seg_scan_unit.sv */
`timescale 1ns / 1ps

module tb_serial_digit_entry_seven_seg_scan_unit;

    localparam int DIGIT_COUNT = sdss_pkg::NUM_DIGITS_DEF;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_ready;
    sdss_pkg::t_in_item  in_item;
    logic                out_valid;
    logic                out_ready;
    sdss_pkg::t_out_item out_item;

    // items waiting to be driven, and display frames still to arrive
    sdss_pkg::t_in_item  pending_items[$];
    sdss_pkg::t_out_item expected_frames[$];

    // shadow copy of the display state
    logic [3:0] shadow_digits[DIGIT_COUNT];
    logic [1:0] shadow_entry_pos = '0;
    logic       shadow_armed     = 1'b0;
    logic [1:0] shadow_scan_pos  = '0;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned calm_cycles;
    int unsigned error_count = 0;

    serial_digit_entry_seven_seg_scan_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // active-low common-anode pattern for one decimal digit
    function automatic logic [7:0] seven_seg_pattern(input logic [3:0] value);
        case (value)
            4'd0:    return 8'hC0;
            4'd1:    return 8'hF9;
            4'd2:    return 8'hA4;
            4'd3:    return 8'hB0;
            4'd4:    return 8'h99;
            4'd5:    return 8'h92;
            4'd6:    return 8'h82;
            4'd7:    return 8'hF8;
            4'd8:    return 8'h80;
            4'd9:    return 8'h90;
            default: return 8'hFF;
        endcase
    endfunction

    function automatic logic is_ascii_digit(input logic [7:0] b);
        return (b >= sdss_pkg::ASCII_ZERO) && (b <= sdss_pkg::ASCII_NINE);
    endfunction

    // update shadow state for one transferred item, queue the frame it yields
    task automatic track_display_item(input sdss_pkg::t_in_item it);
        sdss_pkg::t_out_item frame;
        if (it.action == sdss_pkg::ACT_BYTE) begin
            if (is_ascii_digit(it.rx_byte)) begin
                shadow_digits[shadow_entry_pos] = 4'(it.rx_byte - sdss_pkg::ASCII_ZERO);
                if (shadow_entry_pos == 2'(DIGIT_COUNT - 1)) begin
                    shadow_armed     = 1'b1;
                    shadow_entry_pos = '0;
                end else begin
                    shadow_entry_pos = shadow_entry_pos + 2'd1;
                end
            end else begin
                shadow_entry_pos = '0;
            end
        end else if (shadow_armed) begin
            frame.segments     = seven_seg_pattern(shadow_digits[shadow_scan_pos]);
            frame.digit_enable = 4'hF & ~(4'h1 << shadow_scan_pos);
            expected_frames.push_back(frame);
            shadow_scan_pos = shadow_scan_pos + 2'd1;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %02h want %02h", $realtime, what, got, want);
        error_count++;
    endtask

    // quiet stretches where neither side idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            calm_cycles <= 0;
        end else if (calm_cycles > 0) begin
            calm_cycles <= calm_cycles - 1;
        end else if ($urandom_range(99) < 2) begin
            calm_cycles <= $urandom_range(40, 15);
        end
    end

    // driver: launches the next pending item once the current one transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                track_display_item(in_item);
            end
            if (!in_valid || in_ready) begin
                if (pending_items.size() > 0 &&
                    (calm_cycles > 0 || $urandom_range(99) >= send_idle_pct)) begin
                    in_valid <= 1'b1;
                    in_item  <= pending_items.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        out_ready <= (calm_cycles > 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: compare each transferred frame with the oldest one predicted
    always @(posedge i_clk) begin
        sdss_pkg::t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_frames.size() == 0) begin
                report_mismatch("unexpected frame", int'(out_item), 0);
            end else begin
                want = expected_frames.pop_front();
                if (out_item.segments !== want.segments)
                    report_mismatch("segments", int'(out_item.segments),
                                    int'(want.segments));
                if (out_item.digit_enable !== want.digit_enable)
                    report_mismatch("digit_enable", int'(out_item.digit_enable),
                                    int'(want.digit_enable));
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        sdss_pkg::t_in_item it;
        it.action  = sdss_pkg::ACT_BYTE;
        it.rx_byte = b;
        pending_items.push_back(it);
    endtask

    task automatic push_tick();
        sdss_pkg::t_in_item it;
        it.action  = sdss_pkg::ACT_TICK;
        it.rx_byte = 8'($urandom_range(255));
        pending_items.push_back(it);
    endtask

    function automatic logic [7:0] rand_digit_char();
        return sdss_pkg::ASCII_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_non_digit();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (is_ascii_digit(b))
            b = 8'($urandom_range(255));
        return b;
    endfunction

    // mostly complete four-digit entries, plus tick bursts, broken entries and noise
    task automatic gen_random_items(input int count);
        int unsigned sel;
        int unsigned len;
        int          start;
        start = pending_items.size();
        while (pending_items.size() - start < count) begin
            sel = $urandom_range(99);
            if (sel < 50) begin
                for (int k = 0; k < DIGIT_COUNT; k++) begin
                    push_byte(rand_digit_char());
                    if ($urandom_range(99) < 30)
                        push_tick();
                end
            end else if (sel < 75) begin
                len = $urandom_range(8, 1);
                repeat (len) push_tick();
            end else if (sel < 88) begin
                len = $urandom_range(3, 1);
                repeat (len) push_byte(rand_digit_char());
                push_byte(rand_non_digit());
            end else begin
                push_byte(8'($urandom_range(255)));
            end
        end
    endtask

    // wait until every pending item transferred and every frame arrived
    task automatic drain();
        while (pending_items.size() != 0 || in_valid || expected_frames.size() != 0)
            @(negedge i_clk);
    endtask

    // timeout
    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // stimulus and phase control
    initial begin
        i_rst_n          = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: ticks before armed, byte extremes, restart, wrap, partial refill
        push_tick();
        push_tick();
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(sdss_pkg::ASCII_ZERO - 8'd1);
        push_byte(sdss_pkg::ASCII_NINE + 8'd1);
        push_byte(sdss_pkg::ASCII_ZERO + 8'd5);
        push_byte(sdss_pkg::ASCII_ZERO + 8'd7);
        push_byte(8'h41);
        push_tick();
        push_byte(sdss_pkg::ASCII_ZERO);
        push_byte(sdss_pkg::ASCII_NINE);
        push_byte(sdss_pkg::ASCII_ZERO + 8'd1);
        push_byte(sdss_pkg::ASCII_ZERO + 8'd8);
        repeat (5) push_tick();
        push_byte(sdss_pkg::ASCII_ZERO + 8'd3);
        push_tick();
        push_byte(8'h80);
        repeat (3) push_tick();
        drain();

        // random phases: no idling, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            gen_random_items(475);
            // sender holds off until every frame is back
            drain();
        end

        repeat (10) @(negedge i_clk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
